[hdl/cpb_pkg.sv]
// Shared types, widths and the arctangent table of the polar bearing block.
package cpb_pkg;

    // CORDIC vector width and the fixed point of its scaled magnitudes
    localparam int CORDIC_W     = 64;
    localparam int CORDIC_SCALE = 60;

    // angle accumulator: signed, two full turns of range either way
    localparam int Z_W    = 34;
    localparam int TURN_W = 32;

    localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [TURN_W-1:0] TURN_3QUART  = 32'hC000_0000;

    // quadrant and axis flags that ride along with each beat
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
    } t_quad;

    // atan(2^-i) as a fraction of a full turn, 2^32 = full turn, truncated
    function automatic logic [TURN_W-1:0] atan_turn(input int idx);
        logic [TURN_W-1:0] v;
        case (idx)
            0:  v = 32'h2000_0000;
            1:  v = 32'h12E4_051D;
            2:  v = 32'h09FB_385B;
            3:  v = 32'h0511_11D4;
            4:  v = 32'h028B_0D43;
            5:  v = 32'h0145_D7E1;
            6:  v = 32'h00A2_F61E;
            7:  v = 32'h0051_7C55;
            8:  v = 32'h0028_BE53;
            9:  v = 32'h0014_5F2E;
            10: v = 32'h000A_2F98;
            11: v = 32'h0005_17CC;
            12: v = 32'h0002_8BE6;
            13: v = 32'h0001_45F3;
            14: v = 32'h0000_A2F9;
            15: v = 32'h0000_517C;
            16: v = 32'h0000_28BE;
            17: v = 32'h0000_145F;
            18: v = 32'h0000_0A2F;
            19: v = 32'h0000_0517;
            20: v = 32'h0000_028B;
            21: v = 32'h0000_0145;
            22: v = 32'h0000_00A2;
            23: v = 32'h0000_0051;
            24: v = 32'h0000_0028;
            25: v = 32'h0000_0014;
            26: v = 32'h0000_000A;
            27: v = 32'h0000_0005;
            28: v = 32'h0000_0002;
            29: v = 32'h0000_0001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/cpb_prep.sv]
// Front end: coordinate differences, magnitudes and sum of squares, three stages.
module cpb_prep
    import cpb_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_origin_x,
    input  logic signed [COORD_BITS-1:0] i_origin_y,
    input  logic signed [COORD_BITS-1:0] i_target_x,
    input  logic signed [COORD_BITS-1:0] i_target_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2*COORD_BITS:0]        o_sq,
    output logic [COORD_BITS-1:0]        o_mag_x,
    output logic [COORD_BITS-1:0]        o_mag_y,
    output t_quad                        o_quad
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int LO_W   = (COORD_BITS + 1) / 2;
    localparam int HI_W   = COORD_BITS - LO_W;
    localparam int SQ_W   = 2 * COORD_BITS + 1;

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    // stage 1: differences and magnitudes
    logic signed [DIFF_W-1:0] w_dx, w_dy;
    logic [COORD_BITS-1:0]    n_mag_x, n_mag_y;
    t_quad                    n_quad1;
    logic [COORD_BITS-1:0]    r1_mag_x, r1_mag_y;
    t_quad                    r1_quad;

    // stage 2: partial products of each square
    logic [2*HI_W-1:0]        n_hh_x, n_hh_y, r2_hh_x, r2_hh_y;
    logic [COORD_BITS-1:0]    n_hl_x, n_hl_y, r2_hl_x, r2_hl_y;
    logic [2*LO_W-1:0]        n_ll_x, n_ll_y, r2_ll_x, r2_ll_y;
    logic [COORD_BITS-1:0]    r2_mag_x, r2_mag_y;
    t_quad                    r2_quad;

    // stage 3: sum of squares
    logic [SQ_W-1:0]          n_sq, r3_sq;
    logic [COORD_BITS-1:0]    r3_mag_x, r3_mag_y;
    t_quad                    r3_quad;

    // stage ready chain: a stage moves when empty or its successor moves
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // differences in one extra bit, magnitudes fit the coordinate width
    assign w_dx = $signed({i_target_x[COORD_BITS-1], i_target_x})
                - $signed({i_origin_x[COORD_BITS-1], i_origin_x});
    assign w_dy = $signed({i_target_y[COORD_BITS-1], i_target_y})
                - $signed({i_origin_y[COORD_BITS-1], i_origin_y});

    always_comb begin
        n_mag_x        = w_dx[DIFF_W-1] ? COORD_BITS'(-w_dx) : w_dx[COORD_BITS-1:0];
        n_mag_y        = w_dy[DIFF_W-1] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
        n_quad1.neg_x  = w_dx[DIFF_W-1];
        n_quad1.neg_y  = w_dy[DIFF_W-1];
        n_quad1.zero_x = (n_mag_x == '0);
        n_quad1.zero_y = (n_mag_y == '0);
    end

    // split each magnitude in halves: a^2 = hh<<2L + 2*hl<<L + ll
    assign n_hh_x = (2*HI_W)'(r1_mag_x[COORD_BITS-1:LO_W])
                  * (2*HI_W)'(r1_mag_x[COORD_BITS-1:LO_W]);
    assign n_hl_x = COORD_BITS'(r1_mag_x[COORD_BITS-1:LO_W])
                  * COORD_BITS'(r1_mag_x[LO_W-1:0]);
    assign n_ll_x = (2*LO_W)'(r1_mag_x[LO_W-1:0]) * (2*LO_W)'(r1_mag_x[LO_W-1:0]);
    assign n_hh_y = (2*HI_W)'(r1_mag_y[COORD_BITS-1:LO_W])
                  * (2*HI_W)'(r1_mag_y[COORD_BITS-1:LO_W]);
    assign n_hl_y = COORD_BITS'(r1_mag_y[COORD_BITS-1:LO_W])
                  * COORD_BITS'(r1_mag_y[LO_W-1:0]);
    assign n_ll_y = (2*LO_W)'(r1_mag_y[LO_W-1:0]) * (2*LO_W)'(r1_mag_y[LO_W-1:0]);

    assign n_sq = SQ_W'({r2_hh_x, r2_ll_x}) + SQ_W'({r2_hl_x, {(LO_W+1){1'b0}}})
                + SQ_W'({r2_hh_y, r2_ll_y}) + SQ_W'({r2_hl_y, {(LO_W+1){1'b0}}});

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_mag_x <= n_mag_x;
            r1_mag_y <= n_mag_y;
            r1_quad  <= n_quad1;
        end
        if (w_rdy2) begin
            r2_hh_x  <= n_hh_x;
            r2_hl_x  <= n_hl_x;
            r2_ll_x  <= n_ll_x;
            r2_hh_y  <= n_hh_y;
            r2_hl_y  <= n_hl_y;
            r2_ll_y  <= n_ll_y;
            r2_mag_x <= r1_mag_x;
            r2_mag_y <= r1_mag_y;
            r2_quad  <= r1_quad;
        end
        if (w_rdy3) begin
            r3_sq    <= n_sq;
            r3_mag_x <= r2_mag_x;
            r3_mag_y <= r2_mag_y;
            r3_quad  <= r2_quad;
        end
    end

    assign o_valid = r_v3;
    assign o_sq    = r3_sq;
    assign o_mag_x = r3_mag_x;
    assign o_mag_y = r3_mag_y;
    assign o_quad  = r3_quad;

endmodule

[hdl/cpb_cell.sv]
// One chain cell: a square root digit, a CORDIC rotation or both per beat.
module cpb_cell
    import cpb_pkg::*;
#(
    parameter int COORD_BITS     = 32,
    parameter int ROTATION_STEPS = 18,
    parameter int IDX            = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2*COORD_BITS:0]      i_sq,
    input  logic [COORD_BITS+3:0]      i_rem,
    input  logic [COORD_BITS:0]        i_root,
    input  logic signed [CORDIC_W-1:0] i_p,
    input  logic signed [CORDIC_W-1:0] i_q,
    input  logic signed [Z_W-1:0]      i_z,
    input  t_quad                      i_quad,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2*COORD_BITS:0]      o_sq,
    output logic [COORD_BITS+3:0]      o_rem,
    output logic [COORD_BITS:0]        o_root,
    output logic signed [CORDIC_W-1:0] o_p,
    output logic signed [CORDIC_W-1:0] o_q,
    output logic signed [Z_W-1:0]      o_z,
    output t_quad                      o_quad
);

    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int REM_W  = COORD_BITS + 4;
    localparam int ROOT_W = COORD_BITS + 1;

    logic                       r_valid;
    logic [SQ_W-1:0]            r_sq;
    logic [REM_W-1:0]           r_rem, n_rem;
    logic [ROOT_W-1:0]          r_root, n_root;
    logic signed [CORDIC_W-1:0] r_p, r_q, n_p, n_q;
    logic signed [Z_W-1:0]      r_z, n_z;
    t_quad                      r_quad;

    assign o_ready = !r_valid || i_ready;

    // square root digit, pairs taken from the top of the sum down
    if (IDX <= COORD_BITS) begin : g_sqrt
        localparam int PAIR_I = COORD_BITS - IDX;
        logic [1:0]        w_pair;
        logic [REM_W-1:0]  w_rem_sh, w_trial;
        logic [ROOT_W-1:0] w_root_sh;

        // the top pair has only one bit of the sum in it
        if (IDX == 0) begin : g_top
            assign w_pair = {1'b0, i_sq[SQ_W-1]};
        end else begin : g_mid
            assign w_pair = i_sq[2*PAIR_I+1 -: 2];
        end

        assign w_rem_sh  = {i_rem[REM_W-3:0], w_pair};
        assign w_root_sh = {i_root[ROOT_W-2:0], 1'b0};
        assign w_trial   = REM_W'({w_root_sh, 1'b1});

        always_comb begin
            if (w_rem_sh >= w_trial) begin
                n_rem  = w_rem_sh - w_trial;
                n_root = w_root_sh | ROOT_W'(1);
            end else begin
                n_rem  = w_rem_sh;
                n_root = w_root_sh;
            end
        end
    end else begin : g_sqrt_pass
        assign n_rem  = i_rem;
        assign n_root = i_root;
    end

    // CORDIC vectoring step toward the axis
    if (IDX < ROTATION_STEPS) begin : g_rot
        localparam logic signed [Z_W-1:0] STEP_Z = Z_W'(atan_turn(IDX));
        logic signed [CORDIC_W-1:0] w_ps, w_qs;

        assign w_ps = i_p >>> IDX;
        assign w_qs = i_q >>> IDX;

        always_comb begin
            if (!i_q[CORDIC_W-1]) begin
                n_p = i_p + w_qs;
                n_q = i_q - w_ps;
                n_z = i_z + STEP_Z;
            end else begin
                n_p = i_p - w_qs;
                n_q = i_q + w_ps;
                n_z = i_z - STEP_Z;
            end
        end
    end else begin : g_rot_pass
        assign n_p = i_p;
        assign n_q = i_q;
        assign n_z = i_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sq   <= i_sq;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_p    <= n_p;
            r_q    <= n_q;
            r_z    <= n_z;
            r_quad <= i_quad;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_z     = r_z;
    assign o_quad  = r_quad;

    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem <= REM_W'({r_root, 1'b0})))
        else $error("square root remainder above twice the partial root");

    // the axis component of the vector only grows from a nonnegative start
    a_axis_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_p[CORDIC_W-1])
        else $error("CORDIC axis component went negative");

endmodule

[hdl/cpb_fold.sv]
// Back end: angle clamp, quadrant fold, rounding and the output register.
module cpb_fold
    import cpb_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_BITS:0]    i_root,
    input  logic signed [Z_W-1:0]  i_z,
    input  t_quad                  i_quad,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_BITS+1:0]  o_distance,
    output logic [ANGLE_BITS-1:0]  o_bearing
);

    localparam int DIST_W = COORD_BITS + 2;
    localparam logic [TURN_W-1:0] ROUND_LSB =
        TURN_W'((33'd1 << (TURN_W - ANGLE_BITS)) >> 1);
    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(TURN_QUARTER);
    localparam logic [ANGLE_BITS-1:0] B_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] B_HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] B_3QUART  = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

    logic                  r_valid;
    logic [DIST_W-1:0]     r_distance;
    logic [ANGLE_BITS-1:0] r_bearing, n_bearing;
    logic [TURN_W-1:0]     w_a, w_angle, w_round;

    assign o_ready = !r_valid || i_ready;

    // first quadrant angle, clamped to a quarter turn, zero on the y axis
    always_comb begin
        if (i_quad.zero_x || i_z[Z_W-1]) begin
            w_a = '0;
        end else if (i_z > Z_QUARTER) begin
            w_a = TURN_QUARTER;
        end else begin
            w_a = i_z[TURN_W-1:0];
        end
    end

    // fold into the full turn, wrapping modulo 2^32
    always_comb begin
        if (i_quad.zero_y) begin
            w_angle = i_quad.neg_x ? TURN_3QUART : TURN_QUARTER;
        end else if (!i_quad.neg_y) begin
            w_angle = i_quad.neg_x ? (TURN_W'(0) - w_a) : w_a;
        end else begin
            w_angle = i_quad.neg_x ? (TURN_HALF + w_a) : (TURN_HALF - w_a);
        end
    end

    // round half up to the output resolution
    assign w_round   = w_angle + ROUND_LSB;
    assign n_bearing = w_round[TURN_W-1 -: ANGLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_distance <= DIST_W'(i_root);
            r_bearing  <= n_bearing;
        end
    end

    assign o_valid    = r_valid;
    assign o_distance = r_distance;
    assign o_bearing  = r_bearing;

    // on the x axis the bearing is exactly a quarter or three quarters turn
    a_zero_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_quad.zero_y) |=>
        (o_bearing == ($past(i_quad.neg_x) ? B_3QUART : B_QUARTER)))
        else $error("bearing on the x axis is not a quarter turn multiple");

    // on the y axis the bearing is exactly north or south
    a_zero_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_quad.zero_x && !i_quad.zero_y) |=>
        (o_bearing == ($past(i_quad.neg_y) ? B_HALF : ANGLE_BITS'(0))))
        else $error("bearing on the y axis is not north or south");

endmodule

[hdl/cartesian_to_polar_bearing_top.sv]
// Top level of the polar bearing block: front end, chain of cells, back end.
// Pipeline: three front-end stages, one cell per square root digit or CORDIC
// rotation (whichever are more), one output register.
// Throughput: one beat per cycle; every stage stalls only when it holds a beat.
// Reset clears all valid flags; payload registers are not reset.
module cartesian_to_polar_bearing_top
    import cpb_pkg::*;
#(
    parameter int COORD_BITS     = 32,
    parameter int ANGLE_BITS     = 16,
    parameter int ROTATION_STEPS = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_origin_x,
    input  logic signed [COORD_BITS-1:0] i_origin_y,
    input  logic signed [COORD_BITS-1:0] i_target_x,
    input  logic signed [COORD_BITS-1:0] i_target_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [COORD_BITS+1:0]        o_distance,
    output logic [ANGLE_BITS-1:0]        o_bearing
);

    localparam int NCELL  = (COORD_BITS + 1 > ROTATION_STEPS) ? COORD_BITS + 1
                                                               : ROTATION_STEPS;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int REM_W  = COORD_BITS + 4;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int GUARD  = CORDIC_SCALE - COORD_BITS;

    logic                       w_vld  [0:NCELL];
    logic                       w_rdy  [0:NCELL];
    logic [SQ_W-1:0]            w_sq   [0:NCELL];
    logic [REM_W-1:0]           w_rem  [0:NCELL];
    logic [ROOT_W-1:0]          w_root [0:NCELL];
    logic signed [CORDIC_W-1:0] w_p    [0:NCELL];
    logic signed [CORDIC_W-1:0] w_q    [0:NCELL];
    logic signed [Z_W-1:0]      w_z    [0:NCELL];
    t_quad                      w_quad [0:NCELL];
    logic [COORD_BITS-1:0]      w_mag_x, w_mag_y;

    // differences, magnitudes and sum of squares
    cpb_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .o_valid    (w_vld[0]),
        .i_ready    (w_rdy[0]),
        .o_sq       (w_sq[0]),
        .o_mag_x    (w_mag_x),
        .o_mag_y    (w_mag_y),
        .o_quad     (w_quad[0])
    );

    // seed the chain: empty root, vector scaled up to the fixed point
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_p[0]    = {{(CORDIC_W-CORDIC_SCALE){1'b0}}, w_mag_y, {GUARD{1'b0}}};
    assign w_q[0]    = {{(CORDIC_W-CORDIC_SCALE){1'b0}}, w_mag_x, {GUARD{1'b0}}};
    assign w_z[0]    = '0;

    // chain of cells
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        cpb_cell #(
            .COORD_BITS     (COORD_BITS),
            .ROTATION_STEPS (ROTATION_STEPS),
            .IDX            (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[k]),
            .o_ready (w_rdy[k]),
            .i_sq    (w_sq[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .i_p     (w_p[k]),
            .i_q     (w_q[k]),
            .i_z     (w_z[k]),
            .i_quad  (w_quad[k]),
            .o_valid (w_vld[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_sq    (w_sq[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1]),
            .o_p     (w_p[k+1]),
            .o_q     (w_q[k+1]),
            .o_z     (w_z[k+1]),
            .o_quad  (w_quad[k+1])
        );
    end

    // bearing fold and output register
    cpb_fold #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_fold (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_vld[NCELL]),
        .o_ready    (w_rdy[NCELL]),
        .i_root     (w_root[NCELL]),
        .i_z        (w_z[NCELL]),
        .i_quad     (w_quad[NCELL]),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_distance (o_distance),
        .o_bearing  (o_bearing)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the cartesian_to_polar_bearing_top distance and bearing pipeline.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_PERIOD   = 20;
    localparam int  PIPE_LATENCY = 37;
    localparam int  RANDOM_PAIRS = 1030;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  STALL_CYCLES = 400;
    localparam int  ROT_STEPS    = 18;

    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;

    // turn fractions, 2^32 = full turn
    localparam longint QTR_TURN   = 64'h0000_0000_4000_0000;
    localparam longint HALF_TURN  = 64'h0000_0000_8000_0000;
    localparam longint TQTR_TURN  = 64'h0000_0000_C000_0000;
    localparam longint WHOLE_TURN = 64'h0000_0001_0000_0000;

    // atan(2^-k) in turns, truncated
    localparam longint ARCTAN_TURN [ROT_STEPS] = '{
        64'h2000_0000, 64'h12E4_051D, 64'h09FB_385B, 64'h0511_11D4, 64'h028B_0D43,
        64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55, 64'h0028_BE53, 64'h0014_5F2E,
        64'h000A_2F98, 64'h0005_17CC, 64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2F9,
        64'h0000_517C, 64'h0000_28BE, 64'h0000_145F
    };

    typedef struct {
        logic [33:0] distance;
        logic [15:0] bearing;
    } t_polar;

    // Scoreboard: predicts distance/bearing per accepted beat, checks results in order
    class polar_scoreboard;
        t_polar expected_polar[$];
        int     mismatches;
        int     results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_polar.size();
        endfunction

        function t_polar predict_polar(input logic signed [31:0] ox, oy, tx, ty);
            longint       dx, dy, p, q, z, ps, qs, fq, angle;
            logic [127:0] mx, my, sq, rem, root, trial;
            logic [63:0]  rounded;
            t_polar       r;
            dx = longint'(tx) - longint'(ox);
            dy = longint'(ty) - longint'(oy);
            mx = (dx < 0) ? 128'(-dx) : 128'(dx);
            my = (dy < 0) ? 128'(-dy) : 128'(dy);

            // floor square root, two bits per digit
            sq   = mx * mx + my * my;
            rem  = '0;
            root = '0;
            for (int i = 32; i >= 0; i--) begin
                rem   = (rem << 2) | 128'(sq[2*i +: 2]);
                root  = root << 1;
                trial = (root << 1) | 128'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = root | 128'd1;
                end
            end

            // vectoring rotations on the first-quadrant magnitudes
            p = longint'(my[63:0] << 28);
            q = longint'(mx[63:0] << 28);
            z = 0;
            for (int k = 0; k < ROT_STEPS; k++) begin
                ps = p >>> k;
                qs = q >>> k;
                if (q >= 0) begin
                    p += qs;
                    q -= ps;
                    z += ARCTAN_TURN[k];
                end else begin
                    p -= qs;
                    q += ps;
                    z -= ARCTAN_TURN[k];
                end
            end
            if (z < 0) z = 0;
            if (z > QTR_TURN) z = QTR_TURN;
            fq = (mx == 0) ? 64'd0 : z;

            // fold into the compass quadrant
            if (my == 0)
                angle = (dx < 0) ? TQTR_TURN : QTR_TURN;
            else if (dy > 0)
                angle = (dx < 0) ? WHOLE_TURN - fq : fq;
            else
                angle = (dx < 0) ? HALF_TURN + fq : HALF_TURN - fq;

            rounded    = angle + 64'h8000;
            r.distance = root[33:0];
            r.bearing  = rounded[31:16];
            return r;
        endfunction

        function void note_pair(input logic signed [31:0] ox, oy, tx, ty);
            expected_polar.push_back(predict_polar(ox, oy, tx, ty));
        endfunction

        function void check_result(input logic [33:0] distance, input logic [15:0] bearing);
            t_polar want;
            results_seen++;
            if (expected_polar.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat: expected none, got distance %0d bearing %0d",
                         $time, distance, bearing);
                return;
            end
            want = expected_polar.pop_front();
            if (distance !== want.distance) begin
                mismatches++;
                $display("%0t: distance mismatch: expected %0d, got %0d",
                         $time, want.distance, distance);
            end
            if (bearing !== want.bearing) begin
                mismatches++;
                $display("%0t: bearing mismatch: expected %0d, got %0d",
                         $time, want.bearing, bearing);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_origin_x;
    logic signed [31:0] i_origin_y;
    logic signed [31:0] i_target_x;
    logic signed [31:0] i_target_y;
    logic               o_valid;
    logic               i_ready;
    logic [33:0]        o_distance;
    logic [15:0]        o_bearing;

    polar_scoreboard polar_sb;
    int              pairs_sent;
    logic            steady_run;
    logic            sink_hold;

    cartesian_to_polar_bearing_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_distance (o_distance),
        .o_bearing  (o_bearing)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Offer one point pair and hold it until the block takes the beat
    task automatic send_pair(input logic signed [31:0] ox, oy, tx, ty);
        steady_run = (pairs_sent >= 500 && pairs_sent < 700);
        if (!steady_run && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_origin_x <= ox;
        i_origin_y <= oy;
        i_target_x <= tx;
        i_target_y <= ty;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        polar_sb.note_pair(ox, oy, tx, ty);
        pairs_sent++;
    endtask

    function automatic logic signed [31:0] extreme_coord();
        case ($urandom_range(0, 4))
            0:       return CMIN;
            1:       return CMAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Random pair: full range, near points, axis cases, extreme coordinates and diagonals mixed
    task automatic send_random_pair();
        logic signed [31:0] ox, oy, tx, ty, dlt;
        ox = $urandom;
        oy = $urandom;
        tx = $urandom;
        ty = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5: begin
                tx = ox + int'($urandom_range(0, 2000)) - 1000;
                ty = oy + int'($urandom_range(0, 2000)) - 1000;
            end
            6: begin
                // nearly along one axis
                if ($urandom_range(0, 1)) tx = ox + int'($urandom_range(0, 30)) - 15;
                else ty = oy + int'($urandom_range(0, 30)) - 15;
            end
            7: begin
                if ($urandom_range(0, 1)) tx = ox;
                else ty = oy;
            end
            8: begin
                ox = extreme_coord();
                oy = extreme_coord();
                tx = extreme_coord();
                ty = extreme_coord();
            end
            default: begin
                // equal magnitudes, any quadrant
                dlt = $urandom_range(0, 32'h3FFF_FFFF);
                tx  = $urandom_range(0, 1) ? ox + dlt : ox - dlt;
                ty  = $urandom_range(0, 1) ? oy + dlt : oy - dlt;
            end
        endcase
        send_pair(ox, oy, tx, ty);
    endtask

    // Result side: check each beat, idle at random or hold off when asked
    initial begin : result_sink
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (o_valid && i_ready)
                polar_sb.check_result(o_distance, o_bearing);
            if (sink_hold)
                i_ready <= 1'b0;
            else if (steady_run)
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(0, 99) >= 12);
            @(posedge i_clk);
        end
    end

    // Long output stall so the pipeline fills and backs up into the input
    initial begin : sink_stall
        int held;
        sink_hold = 1'b0;
        wait (pairs_sent >= 300);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        for (held = 0; held < STALL_CYCLES; held++) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // Watchdog
    initial begin : watchdog
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding", cyc, polar_sb.pending());
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        polar_sb   = new();
        pairs_sent = 0;
        steady_run = 1'b0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_origin_x <= '0;
        i_origin_y <= '0;
        i_target_x <= '0;
        i_target_y <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector and coincident points
        send_pair(0, 0, 0, 0);
        send_pair(5, 5, 5, 5);
        // on-axis vectors
        send_pair(0, 0, 100, 0);
        send_pair(0, 0, -100, 0);
        send_pair(0, 0, 0, 100);
        send_pair(0, 0, 0, -100);
        // one per quadrant
        send_pair(0, 0, 3, 4);
        send_pair(0, 0, -3, 4);
        send_pair(0, 0, 3, -4);
        send_pair(0, 0, -3, -4);
        send_pair(10, 10, 17, 17);
        send_pair(10, 10, 3, 3);
        // largest differences
        send_pair(CMIN, CMIN, CMAX, CMAX);
        send_pair(CMAX, CMAX, CMIN, CMIN);
        send_pair(CMIN, CMAX, CMAX, CMIN);
        send_pair(CMAX, CMIN, CMIN, CMAX);
        // nearly on an axis: shallow, steep, and just left of north
        send_pair(CMIN, 0, CMAX, 1);
        send_pair(0, CMIN, 1, CMAX);
        send_pair(0, CMIN, -1, CMAX);
        send_pair(-1, -1, -1, -1);
        send_pair(0, 0, -1, -1);
        send_pair(CMIN, CMIN, CMIN + 1, CMIN + 1);

        repeat (RANDOM_PAIRS) send_random_pair();
        i_valid <= 1'b0;

        // drain, then watch for stray beats
        while (polar_sb.pending() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("%0d point pairs sent, %0d results checked, %0d mismatches",
                 pairs_sent, polar_sb.results_seen, polar_sb.mismatches);
        $display("covered axis, quadrant, diagonal and extreme points, idling, one long stall");
        if (polar_sb.mismatches == 0 && polar_sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
